>>> rtl/nrt_pkg.sv
`default_nettype none
package nrt_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_NODE_COUNT  = 64;
   localparam int DEF_ADDR_BITS   = 52;

   localparam int NODE_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_CLEANUP = 2'd1,
      CMD_FILL    = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_IGNORED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_OVERLAP  = 3'd3,
      ST_NO_RANGE = 3'd4
   } status_type;

   typedef enum logic {
      CSR_DRAM_START = 1'b0,
      CSR_DRAM_END   = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

>>> rtl/nrt_ram.sv
`default_nettype none
module nrt_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/node_range_table.sv
// Channel  Direction  Ports                                   Moves
// req      in         req_valid, req_stall, req_* fields      one command transaction
// rsp      out        rsp_valid, rsp_stall, rsp_* fields      one result transaction
// csr      in         csr_wr_en, csr_index, csr_wdata          register write, no wait
//
// One command is worked at a time; the entry table sits in a single-port-read RAM,
// so every table read takes an address, then gives registered data. Cleanup runs a
// clip pass, then pairwise merge checks with a full scan each, then shifts. Fill does
// one scan per selected range in the span, then rewrites those ranges. Reset is
// synchronous and clears the count; the RAM is not cleared. A result waiting on
// rsp_stall does not keep the next command from being taken; only its result waits.
`default_nettype none
module node_range_table #(
   parameter int TABLE_DEPTH = nrt_pkg::DEF_TABLE_DEPTH,
   parameter int NODE_COUNT  = nrt_pkg::DEF_NODE_COUNT,
   parameter int ADDR_BITS   = nrt_pkg::DEF_ADDR_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [nrt_pkg::NODE_W-1:0]    req_node_id,
   input  wire logic [ADDR_BITS-1:0]          req_range_start,
   input  wire logic [ADDR_BITS-1:0]          req_range_end,
   input  wire logic [nrt_pkg::INDEX_W-1:0]   req_entry_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [nrt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ADDR_BITS-1:0]               rsp_entry_start,
   output logic [ADDR_BITS-1:0]               rsp_entry_end,
   output logic [nrt_pkg::NODE_W-1:0]         rsp_entry_node,
   output logic [nrt_pkg::COUNT_W-1:0]        rsp_entry_count,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_index,
   input  wire logic [ADDR_BITS-1:0]          csr_wdata
);

   import nrt_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 2 * AW + NODE_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   typedef enum logic [4:0] {
      S_IDLE, S_ADD, S_RD_ISSUE, S_RD_DATA,
      S_CL_CLIP_RD, S_CL_CLIP_WR, S_CL_I_RD, S_CL_I_DATA,
      S_CL_J_RD, S_CL_J_DATA, S_CL_K_RD, S_CL_K_DATA,
      S_CL_SH_RD, S_CL_SH_WR,
      S_FL_SCAN_RD, S_FL_SCAN_DATA, S_FL_L_RD, S_FL_L_DATA, S_FL_E_DATA,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] dram_start_ff, dram_end_ff;

   cmd_type       cmd_ff, cmd_in;
   logic [NODE_W-1:0]  nid_ff, nid_in;
   logic [AW-1:0]      s_ff, s_in, e_ff, e_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, w_ff, w_in, m_ff, m_in;
   logic [AW-1:0] ri_start_ff, ri_start_in, ri_end_ff, ri_end_in;
   logic [NODE_W-1:0] ri_node_ff, ri_node_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in;
   logic [CW-1:0] last_idx_ff, last_idx_in, best_idx_ff, best_idx_in;
   logic [AW-1:0] last_start_ff, last_start_in, best_start_ff, best_start_in;
   logic          have_last_ff, have_last_in, best_found_ff, best_found_in;
   logic [AW-1:0] prev_end_ff, prev_end_in;
   logic [IW-1:0] cur_ff, cur_in;

   status_type    res_status_ff, res_status_in;
   logic [AW-1:0] res_start_ff, res_start_in, res_end_ff, res_end_in;
   logic [NODE_W-1:0] res_node_ff, res_node_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [AW-1:0]        rsp_start_ff, rsp_start_in, rsp_end_ff, rsp_end_in;
   logic [NODE_W-1:0]    rsp_node_ff, rsp_node_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic          ent_wr_en, ent_rd_en;
   logic [IW-1:0] ent_wr_addr, ent_rd_addr;
   logic [EW-1:0] ent_wr_data, ent_rd_data;
   logic          list_wr_en, list_rd_en;
   logic [IW-1:0] list_wr_addr, list_wr_data, list_rd_addr, list_rd_data;

   logic [AW-1:0]     rd_start, rd_end;
   logic [NODE_W-1:0] rd_node;
   logic [AW-1:0]     clip_start, clip_end;
   logic              fl_first, fl_last;
   logic [AW-1:0]     fl_end, fl_start, fl_prev;
   logic              fl_cand;

   assign rd_start = ent_rd_data[EW-1 -: AW];
   assign rd_end   = ent_rd_data[AW+NODE_W-1 -: AW];
   assign rd_node  = ent_rd_data[NODE_W-1:0];

   assign clip_start = (rd_start < dram_start_ff) ? dram_start_ff : rd_start;
   assign clip_end   = (rd_end > dram_end_ff) ? dram_end_ff : rd_end;

   assign fl_first = (pos_ff == '0);
   assign fl_last  = (pos_ff == (cnt_ff - ONE_C));
   assign fl_end   = (fl_last && (e_ff > rd_end)) ? e_ff : rd_end;

   always_comb begin
      if (fl_first) begin
         fl_start = (s_ff < rd_start) ? s_ff : rd_start;
         fl_prev  = fl_end;
      end else if (prev_end_ff >= rd_start) begin
         fl_start = rd_start;
         fl_prev  = (prev_end_ff < fl_end) ? fl_end : prev_end_ff;
      end else begin
         fl_start = prev_end_ff;
         fl_prev  = fl_end;
      end
   end

   assign fl_cand = (s_ff < rd_end) && (rd_start < e_ff) &&
                    (!have_last_ff || (rd_start > last_start_ff) ||
                     ((rd_start == last_start_ff) && (k_ff > last_idx_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         dram_start_ff <= '0;
         dram_end_ff   <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRAM_START: dram_start_ff <= csr_wdata;
            CSR_DRAM_END:   dram_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; nid_in = nid_ff; s_in = s_ff; e_in = e_ff; idx_in = idx_ff;
      count_in = count_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; w_in = w_ff; m_in = m_ff;
      ri_start_in = ri_start_ff; ri_end_in = ri_end_ff; ri_node_in = ri_node_ff;
      lo_in = lo_ff; hi_in = hi_ff;
      cnt_in = cnt_ff; pos_in = pos_ff;
      last_idx_in = last_idx_ff; last_start_in = last_start_ff;
      best_idx_in = best_idx_ff; best_start_in = best_start_ff;
      have_last_in = have_last_ff; best_found_in = best_found_ff;
      prev_end_in = prev_end_ff; cur_in = cur_ff;
      res_status_in = res_status_ff; res_start_in = res_start_ff;
      res_end_in = res_end_ff; res_node_in = res_node_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_start_in = rsp_start_ff;
      rsp_end_in = rsp_end_ff; rsp_node_in = rsp_node_ff; rsp_count_in = rsp_count_ff;

      ent_wr_en = 1'b0; ent_wr_addr = '0; ent_wr_data = '0;
      ent_rd_en = 1'b0; ent_rd_addr = '0;
      list_wr_en = 1'b0; list_wr_addr = '0; list_wr_data = '0;
      list_rd_en = 1'b0; list_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = cmd_type'(req_cmd);
               nid_in = req_node_id;
               s_in = req_range_start;
               e_in = req_range_end;
               idx_in = req_entry_index;
               res_status_in = ST_OK;
               res_start_in = '0;
               res_end_in = '0;
               res_node_in = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_ADD: state_in = S_ADD;
                  CMD_CLEANUP: begin
                     i_in = '0;
                     w_in = '0;
                     state_in = S_CL_CLIP_RD;
                  end
                  CMD_FILL: begin
                     cnt_in = '0;
                     k_in = '0;
                     have_last_in = 1'b0;
                     best_found_in = 1'b0;
                     state_in = S_FL_SCAN_RD;
                  end
                  CMD_READ: state_in = S_RD_ISSUE;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if ((s_ff >= e_ff) || ({1'b0, nid_ff} >= (NODE_W+1)'(NODE_COUNT))) begin
               res_status_in = ST_IGNORED;
            end else if (count_ff >= DEPTH_C) begin
               res_status_in = ST_FULL;
            end else begin
               ent_wr_en = 1'b1;
               ent_wr_addr = count_ff[IW-1:0];
               ent_wr_data = {s_ff, e_ff, nid_ff};
               count_in = count_ff + ONE_C;
            end
            state_in = S_RESP;
         end
         S_RD_ISSUE: begin
            if (32'(idx_ff) < 32'(count_ff)) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = IW'(idx_ff);
               state_in = S_RD_DATA;
            end else begin
               res_status_in = ST_IGNORED;
               state_in = S_RESP;
            end
         end
         S_RD_DATA: begin
            res_start_in = rd_start;
            res_end_in = rd_end;
            res_node_in = rd_node;
            state_in = S_RESP;
         end
         S_CL_CLIP_RD: begin
            if (i_ff < count_ff) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = i_ff[IW-1:0];
               state_in = S_CL_CLIP_WR;
            end else begin
               count_in = w_ff;
               i_in = '0;
               state_in = S_CL_I_RD;
            end
         end
         S_CL_CLIP_WR: begin
            if (clip_start < clip_end) begin
               ent_wr_en = 1'b1;
               ent_wr_addr = w_ff[IW-1:0];
               ent_wr_data = {clip_start, clip_end, rd_node};
               w_in = w_ff + ONE_C;
            end
            i_in = i_ff + ONE_C;
            state_in = S_CL_CLIP_RD;
         end
         S_CL_I_RD: begin
            if (i_ff < count_ff) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = i_ff[IW-1:0];
               j_in = i_ff + ONE_C;
               state_in = S_CL_I_DATA;
            end else begin
               res_status_in = ST_OK;
               state_in = S_RESP;
            end
         end
         S_CL_I_DATA: begin
            ri_start_in = rd_start;
            ri_end_in = rd_end;
            ri_node_in = rd_node;
            state_in = S_CL_J_RD;
         end
         S_CL_J_RD: begin
            if (j_ff < count_ff) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = j_ff[IW-1:0];
               state_in = S_CL_J_DATA;
            end else begin
               i_in = i_ff + ONE_C;
               state_in = S_CL_I_RD;
            end
         end
         S_CL_J_DATA: begin
            if (ri_node_ff != rd_node) begin
               if ((ri_end_ff > rd_start) && (ri_start_ff < rd_end)) begin
                  res_status_in = ST_OVERLAP;
                  state_in = S_RESP;
               end else begin
                  j_in = j_ff + ONE_C;
                  state_in = S_CL_J_RD;
               end
            end else begin
               lo_in = (ri_start_ff < rd_start) ? ri_start_ff : rd_start;
               hi_in = (ri_end_ff > rd_end) ? ri_end_ff : rd_end;
               k_in = '0;
               state_in = S_CL_K_RD;
            end
         end
         S_CL_K_RD: begin
            if (k_ff < count_ff) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = k_ff[IW-1:0];
               state_in = S_CL_K_DATA;
            end else begin
               ent_wr_en = 1'b1;
               ent_wr_addr = i_ff[IW-1:0];
               ent_wr_data = {lo_ff, hi_ff, ri_node_ff};
               ri_start_in = lo_ff;
               ri_end_in = hi_ff;
               m_in = j_ff;
               state_in = S_CL_SH_RD;
            end
         end
         S_CL_K_DATA: begin
            if ((rd_node != ri_node_ff) && (lo_ff < rd_end) && (hi_ff > rd_start)) begin
               j_in = j_ff + ONE_C;
               state_in = S_CL_J_RD;
            end else begin
               k_in = k_ff + ONE_C;
               state_in = S_CL_K_RD;
            end
         end
         S_CL_SH_RD: begin
            if ((m_ff + ONE_C) < count_ff) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = m_in[IW-1:0] + IW'(1);
               state_in = S_CL_SH_WR;
            end else begin
               count_in = count_ff - ONE_C;
               state_in = S_CL_J_RD;
            end
         end
         S_CL_SH_WR: begin
            ent_wr_en = 1'b1;
            ent_wr_addr = m_ff[IW-1:0];
            ent_wr_data = ent_rd_data;
            m_in = m_ff + ONE_C;
            state_in = S_CL_SH_RD;
         end
         S_FL_SCAN_RD: begin
            if (k_ff < count_ff) begin
               ent_rd_en = 1'b1;
               ent_rd_addr = k_ff[IW-1:0];
               state_in = S_FL_SCAN_DATA;
            end else if (best_found_ff) begin
               list_wr_en = 1'b1;
               list_wr_addr = cnt_ff[IW-1:0];
               list_wr_data = best_idx_ff[IW-1:0];
               cnt_in = cnt_ff + ONE_C;
               last_start_in = best_start_ff;
               last_idx_in = best_idx_ff;
               have_last_in = 1'b1;
               best_found_in = 1'b0;
               k_in = '0;
            end else if (cnt_ff == '0) begin
               res_status_in = ST_NO_RANGE;
               state_in = S_RESP;
            end else begin
               pos_in = '0;
               state_in = S_FL_L_RD;
            end
         end
         S_FL_SCAN_DATA: begin
            if (fl_cand && (!best_found_ff || (rd_start < best_start_ff))) begin
               best_found_in = 1'b1;
               best_start_in = rd_start;
               best_idx_in = k_ff;
            end
            k_in = k_ff + ONE_C;
            state_in = S_FL_SCAN_RD;
         end
         S_FL_L_RD: begin
            if (pos_ff < cnt_ff) begin
               list_rd_en = 1'b1;
               list_rd_addr = pos_ff[IW-1:0];
               state_in = S_FL_L_DATA;
            end else begin
               res_status_in = ST_OK;
               state_in = S_RESP;
            end
         end
         S_FL_L_DATA: begin
            ent_rd_en = 1'b1;
            ent_rd_addr = list_rd_data;
            cur_in = list_rd_data;
            state_in = S_FL_E_DATA;
         end
         S_FL_E_DATA: begin
            ent_wr_en = 1'b1;
            ent_wr_addr = cur_ff;
            ent_wr_data = {fl_start, fl_end, rd_node};
            prev_end_in = fl_prev;
            pos_in = pos_ff + ONE_C;
            state_in = S_FL_L_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in = res_start_ff;
               rsp_end_in = res_end_ff;
               rsp_node_in = res_node_ff;
               rsp_count_in = COUNT_W'(count_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; nid_ff <= nid_in; s_ff <= s_in; e_ff <= e_in; idx_ff <= idx_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; w_ff <= w_in; m_ff <= m_in;
      ri_start_ff <= ri_start_in; ri_end_ff <= ri_end_in; ri_node_ff <= ri_node_in;
      lo_ff <= lo_in; hi_ff <= hi_in;
      cnt_ff <= cnt_in; pos_ff <= pos_in;
      last_idx_ff <= last_idx_in; last_start_ff <= last_start_in;
      best_idx_ff <= best_idx_in; best_start_ff <= best_start_in;
      have_last_ff <= have_last_in; best_found_ff <= best_found_in;
      prev_end_ff <= prev_end_in; cur_ff <= cur_in;
      res_status_ff <= res_status_in; res_start_ff <= res_start_in;
      res_end_ff <= res_end_in; res_node_ff <= res_node_in;
      rsp_status_ff <= rsp_status_in; rsp_start_ff <= rsp_start_in;
      rsp_end_ff <= rsp_end_in; rsp_node_ff <= rsp_node_in; rsp_count_ff <= rsp_count_in;
   end

   nrt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   nrt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(IW)) u_order_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_start = rsp_start_ff;
   assign rsp_entry_end   = rsp_end_ff;
   assign rsp_entry_node  = rsp_node_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

>>> rtl/nrt_check.sv
`default_nettype none
module nrt_check #(
   parameter int TABLE_DEPTH = nrt_pkg::DEF_TABLE_DEPTH,
   parameter int ADDR_BITS   = nrt_pkg::DEF_ADDR_BITS
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [nrt_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [ADDR_BITS-1:0]          rsp_entry_start,
   input wire logic [ADDR_BITS-1:0]          rsp_entry_end,
   input wire logic [nrt_pkg::NODE_W-1:0]    rsp_entry_node,
   input wire logic [nrt_pkg::COUNT_W-1:0]   rsp_entry_count
);

   import nrt_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

   // A stalled result transaction stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_start) && $stable(rsp_entry_count))
      else $error("result changed while stalled");

   // Only a successful read returns entry contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_entry_start == '0) && (rsp_entry_end == '0) && (rsp_entry_node == '0))
      else $error("entry fields set on a failed command");

   // A full table reports the full count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == FULL_COUNT)
      else $error("table full reported with a short count");

   // Every stored range is nonempty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_end != '0) |-> rsp_entry_start < rsp_entry_end)
      else $error("empty or reversed range read back");

endmodule

bind node_range_table nrt_check #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .ADDR_BITS   (ADDR_BITS)
) u_nrt_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_start (rsp_entry_start),
   .rsp_entry_end   (rsp_entry_end),
   .rsp_entry_node  (rsp_entry_node),
   .rsp_entry_count (rsp_entry_count)
);
`default_nettype wire
